@@ sv/sck_pkg.sv @@
// Package for the spherical covariance kernel: fixed-point widths, constants,
// register index codes and the result flag struct. No dependencies.
`default_nettype none

package sck_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_DIMS_DEF = 3;
  localparam int NUM_COORDS   = 3;
  localparam int COORD_W      = 32;
  localparam int CFG_W        = 32;
  localparam int COV_W        = 48;
  localparam int ADDR_W       = 5;
  localparam int DIMS_W       = 2;
  // Width of a scaled difference after the first shift.
  localparam int E_W          = COORD_W + CFG_W - FRAC_BITS;
  // Width of amplitude squared after the shift.
  localparam int AMP2_W       = 2 * CFG_W - FRAC_BITS;

  localparam logic [FRAC_BITS:0] ONE_FX   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0]   ONE_CFG  = CFG_W'(1) << FRAC_BITS;
  localparam logic [DIMS_W-1:0]  DIMS_RST = DIMS_W'(3);
  localparam logic [COV_W-1:0]   COV_MAX  = {COV_W{1'b1}};

  typedef enum logic [2:0] {
    REG_INV_SCALE_0 = 3'd0,
    REG_INV_SCALE_1 = 3'd1,
    REG_INV_SCALE_2 = 3'd2,
    REG_INV_RADIUS  = 3'd3,
    REG_AMPLITUDE   = 3'd4,
    REG_NUGGET      = 3'd5,
    REG_DIMS        = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic outside;
    logic origin;
  } res_flags_t;

endpackage

`default_nettype wire

@@ sv/spherical_covariance_kernel_top.sv @@
// Top level of the spherical covariance kernel: register port, coordinate
// lanes, merge stage, square root and shape. Depends on sck_pkg, sck_lane,
// sck_isqrt and sck_shape.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | s_coord_{0..2}_i, t_coord_{0..2}_i
//   out     | source    | out_valid_o/out_stall_i| covariance_o, at_origin_o,
//           |           |                       | outside_support_o
//   apb     | sink      | psel/penable/pready   | paddr, pwdata, prdata
//
// One point pair enters per cycle while the output is not stalled; results leave in order
// through the lanes, the merge stage, the square root (one bit per stage) and the shape.
// Reset clears the valid pipeline and loads the register defaults.
// A stalled valid output freezes the datapath pipeline; the input is stalled only then.
`default_nettype none

module spherical_covariance_kernel_top
  import sck_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] s_coord_0_i,
  input  logic [COORD_W-1:0] s_coord_1_i,
  input  logic [COORD_W-1:0] s_coord_2_i,
  input  logic [COORD_W-1:0] t_coord_0_i,
  input  logic [COORD_W-1:0] t_coord_1_i,
  input  logic [COORD_W-1:0] t_coord_2_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COV_W-1:0]   covariance_o,
  output logic               at_origin_o,
  output logic               outside_support_o
);

  // Only the coordinates that a transaction carries can be taken into the norm.
  localparam int LANES = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
  localparam int SQ_W  = 2 * FRAC_BITS;
  localparam int SUM_W = SQ_W + $clog2(LANES + 1);
  localparam int R_W   = (SUM_W + 1) / 2;
  localparam int DEPTH = 4 + 1 + R_W + 4;

  // Register file.
  logic [CFG_W-1:0]  isc0_q, isc1_q, isc2_q, irad_q, amp_q, nug_q;
  logic [DIMS_W-1:0] dims_q;
  logic              wr_en;
  reg_idx_e          widx, ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:2]);
  assign ridx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isc0_q <= ONE_CFG;
      isc1_q <= ONE_CFG;
      isc2_q <= ONE_CFG;
      irad_q <= ONE_CFG;
      amp_q  <= ONE_CFG;
      nug_q  <= '0;
      dims_q <= DIMS_RST;
    end else if (wr_en) begin
      case (widx)
        REG_INV_SCALE_0: isc0_q <= pwdata;
        REG_INV_SCALE_1: isc1_q <= pwdata;
        REG_INV_SCALE_2: isc2_q <= pwdata;
        REG_INV_RADIUS:  irad_q <= pwdata;
        REG_AMPLITUDE:   amp_q  <= pwdata;
        REG_NUGGET:      nug_q  <= pwdata;
        REG_DIMS:        dims_q <= pwdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_INV_SCALE_0: prdata = isc0_q;
      REG_INV_SCALE_1: prdata = isc1_q;
      REG_INV_SCALE_2: prdata = isc2_q;
      REG_INV_RADIUS:  prdata = irad_q;
      REG_AMPLITUDE:   prdata = amp_q;
      REG_NUGGET:      prdata = nug_q;
      REG_DIMS:        prdata = CFG_W'(dims_q);
      default:         prdata = '0;
    endcase
  end

  // Valid pipeline; the whole datapath advances together.
  logic [DEPTH-1:0] vld_q;
  logic             adv;

  assign adv        = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Lanes.
  logic [COORD_W-1:0] s_arr [NUM_COORDS];
  logic [COORD_W-1:0] t_arr [NUM_COORDS];
  logic [CFG_W-1:0]   isc_arr [NUM_COORDS];
  logic [SQ_W-1:0]    sq  [LANES];
  logic               ovr [LANES];

  assign s_arr   = '{s_coord_0_i, s_coord_1_i, s_coord_2_i};
  assign t_arr   = '{t_coord_0_i, t_coord_1_i, t_coord_2_i};
  assign isc_arr = '{isc0_q, isc1_q, isc2_q};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sck_lane u_lane (
      .clk_i        (clk_i),
      .adv_i        (adv),
      .en_i         (32'(dims_q) > 32'(g)),
      .s_i          (s_arr[g]),
      .t_i          (t_arr[g]),
      .inv_scale_i  (isc_arr[g]),
      .inv_radius_i (irad_q),
      .sq_o         (sq[g]),
      .over_o       (ovr[g])
    );
  end

  // Merge stage: sum of squares and any lane past the support.
  logic [SUM_W-1:0] sum_d, sum_q;
  logic             over_d, over_q;

  always_comb begin
    sum_d  = '0;
    over_d = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sum_d  = sum_d + SUM_W'(sq[i]);
      over_d = over_d | ovr[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q  <= sum_d;
      over_q <= over_d;
    end
  end

  logic [R_W-1:0] z;
  logic           z_over;
  res_flags_t     flags;

  sck_isqrt #(.SUM_W(SUM_W)) u_isqrt (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sum_i  (sum_q),
    .over_i (over_q),
    .z_o    (z),
    .over_o (z_over)
  );

  sck_shape #(.R_W(R_W)) u_shape (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .z_i          (z),
    .over_i       (z_over),
    .amplitude_i  (amp_q),
    .nugget_i     (nug_q),
    .covariance_o (covariance_o),
    .flags_o      (flags)
  );

  assign out_valid_o       = vld_q[DEPTH-1];
  assign at_origin_o       = flags.origin;
  assign outside_support_o = flags.outside;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(at_origin_o && outside_support_o))
    else $error("origin and outside flags both set");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_support_o) |-> (covariance_o == '0))
    else $error("nonzero covariance outside the support");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction missing from the pipeline");

endmodule

`default_nettype wire

@@ sv/sck_lane.sv @@
// One coordinate lane: absolute difference, inverse scale, inverse radius
// and square, four register stages. Depends on sck_pkg.
`default_nettype none

module sck_lane
  import sck_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  logic                     en_i,
  input  logic [COORD_W-1:0]       s_i,
  input  logic [COORD_W-1:0]       t_i,
  input  logic [CFG_W-1:0]         inv_scale_i,
  input  logic [CFG_W-1:0]         inv_radius_i,
  output logic [2*FRAC_BITS-1:0]   sq_o,
  output logic                     over_o
);

  logic signed [COORD_W:0]     diff;
  logic        [COORD_W:0]     neg;
  logic        [COORD_W-1:0]   d_d, d_q;
  logic                        use1_q, use2_q;
  logic [COORD_W+CFG_W-1:0]    prod_e;
  logic [E_W-1:0]              e_q;
  logic                        big;
  logic [2*FRAC_BITS+CFG_W-1:0] wp;
  logic                        over_d, over3_q, over4_q;
  logic [FRAC_BITS-1:0]        w_d, w_q;
  logic [2*FRAC_BITS-1:0]      sq_q;

  assign diff = $signed({s_i[COORD_W-1], s_i}) - $signed({t_i[COORD_W-1], t_i});
  assign neg  = -diff;
  // The magnitude never exceeds 2^32-1, so it fits the coordinate width.
  assign d_d  = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];

  assign prod_e = d_q * inv_scale_i;

  // A scaled difference at or above 2^(2F) reaches one with any nonzero radius.
  assign big    = (|e_q[E_W-1:2*FRAC_BITS]) && (|inv_radius_i);
  assign wp     = e_q[2*FRAC_BITS-1:0] * inv_radius_i;
  assign over_d = use2_q && (big || (|wp[2*FRAC_BITS+CFG_W-1:2*FRAC_BITS]));
  assign w_d    = use2_q ? wp[2*FRAC_BITS-1:FRAC_BITS] : '0;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q     <= d_d;
      use1_q  <= en_i;
      e_q     <= prod_e[COORD_W+CFG_W-1:FRAC_BITS];
      use2_q  <= use1_q;
      w_q     <= w_d;
      over3_q <= over_d;
      sq_q    <= w_q * w_q;
      over4_q <= over3_q;
    end
  end

  assign sq_o   = sq_q;
  assign over_o = over4_q;

endmodule

`default_nettype wire

@@ sv/sck_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage, with
// the outside-support flag carried alongside. Depends on sck_pkg.
`default_nettype none

module sck_isqrt
  import sck_pkg::*;
#(
  parameter int SUM_W = 2 * FRAC_BITS + 2
) (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [SUM_W-1:0]            sum_i,
  input  logic                        over_i,
  output logic [(SUM_W+1)/2-1:0]      z_o,
  output logic                        over_o
);

  localparam int R_W = (SUM_W + 1) / 2;

  logic [SUM_W-1:0] rem_q  [R_W];
  logic [R_W-1:0]   root_q [R_W];
  logic             ov_q   [R_W];

  for (genvar g = 0; g < R_W; g++) begin : g_stage
    localparam int K = R_W - 1 - g;
    logic [SUM_W-1:0] rem_in, rem_d;
    logic [R_W-1:0]   root_in, root_d;
    logic             ov_in;
    logic [SUM_W+1:0] trial;
    logic             take;

    if (g == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign ov_in   = over_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign ov_in   = ov_q[g-1];
    end

    // Setting bit K of the root raises its square by 2*root*2^K + 2^(2K).
    assign trial  = ((SUM_W+2)'(root_in) << (K + 1)) | ((SUM_W+2)'(1) << (2 * K));
    assign take   = {2'b00, rem_in} >= trial;
    assign rem_d  = take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
    assign root_d = take ? (root_in | (R_W'(1) << K)) : root_in;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        ov_q[g]   <= ov_in;
      end
    end
  end

  assign z_o    = root_q[R_W-1];
  assign over_o = ov_q[R_W-1];

endmodule

`default_nettype wire

@@ sv/sck_shape.sv @@
// Kernel shape and scaling: the spherical polynomial in z, the amplitude
// products and the output register; also the origin value from the
// configuration. Depends on sck_pkg.
`default_nettype none

module sck_shape
  import sck_pkg::*;
#(
  parameter int R_W = FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [R_W-1:0]     z_i,
  input  logic               over_i,
  input  logic [CFG_W-1:0]   amplitude_i,
  input  logic [CFG_W-1:0]   nugget_i,
  output logic [COV_W-1:0]   covariance_o,
  output res_flags_t         flags_o
);

  localparam int HI_W = AMP2_W - 32;
  localparam int NF_W = CFG_W + 1;
  localparam int IW   = AMP2_W + FRAC_BITS + 1;
  localparam int OW   = AMP2_W + NF_W;

  // Origin value, refreshed every cycle from the configuration.
  logic [2*CFG_W-1:0]      ap;
  logic [AMP2_W-1:0]       amp2_q;
  logic [NF_W-1:0]         nf;
  logic [32+NF_W-1:0]      olo_q;
  logic [HI_W+NF_W-1:0]    ohi_q;
  logic [OW-1:0]           otot;
  logic [OW-FRAC_BITS-1:0] osh;
  logic [COV_W-1:0]        origin_q;

  assign ap   = amplitude_i * amplitude_i;
  assign nf   = {1'b0, nugget_i} + NF_W'(ONE_CFG);
  assign otot = {ohi_q, 32'b0} + OW'(olo_q);
  assign osh  = otot[OW-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    amp2_q   <= ap[2*CFG_W-1:FRAC_BITS];
    olo_q    <= amp2_q[31:0] * nf;
    ohi_q    <= amp2_q[AMP2_W-1:32] * nf;
    origin_q <= (|osh[OW-FRAC_BITS-1:COV_W]) ? COV_MAX : osh[COV_W-1:0];
  end

  // Polynomial path.
  logic [FRAC_BITS-1:0]     zl, zl_q;
  logic [2*FRAC_BITS-1:0]   zz;
  logic [FRAC_BITS-1:0]     z2_q;
  logic [FRAC_BITS+1:0]     three_m;
  logic [2*FRAC_BITS+1:0]   hp;
  logic [FRAC_BITS:0]       h, p_d, p_q;
  logic [32+FRAC_BITS:0]    plo_q;
  logic [HI_W+FRAC_BITS:0]  phi_q;
  logic [IW-1:0]            isum;
  logic [IW-FRAC_BITS-1:0]  interior;
  res_flags_t               fa_d, fa_q, fb_q, fc_q, fo_q;
  logic [COV_W-1:0]         cov_d, cov_q;

  assign zl          = z_i[FRAC_BITS-1:0];
  assign zz          = zl * zl;
  assign fa_d.outside = over_i || (|z_i[R_W-1:FRAC_BITS]);
  assign fa_d.origin  = !over_i && (z_i == '0);

  assign three_m = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(ONE_FX) - {2'b00, z2_q};
  assign hp      = zl_q * three_m;
  assign h       = hp[2*FRAC_BITS+1:FRAC_BITS+1];
  assign p_d     = (h > ONE_FX) ? '0 : (ONE_FX - h);

  assign isum     = {phi_q, 32'b0} + IW'(plo_q);
  assign interior = isum[IW-1:FRAC_BITS];

  always_comb begin
    cov_d = interior[COV_W-1:0];
    if (fc_q.outside) begin
      cov_d = '0;
    end else if (fc_q.origin) begin
      cov_d = origin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zl_q  <= zl;
      z2_q  <= zz[2*FRAC_BITS-1:FRAC_BITS];
      fa_q  <= fa_d;
      p_q   <= p_d;
      fb_q  <= fa_q;
      plo_q <= amp2_q[31:0] * p_q;
      phi_q <= amp2_q[AMP2_W-1:32] * p_q;
      fc_q  <= fb_q;
      cov_q <= cov_d;
      fo_q  <= fc_q;
    end
  end

  assign covariance_o = cov_q;
  assign flags_o      = fo_q;

endmodule

`default_nettype wire
